### design/cfmp_pkg.sv
// ---------------------------------------------------------------------------
// cfmp_pkg
// Shared types, default sizes and the element mass table of the species-name
// mass parser.
// ---------------------------------------------------------------------------
package cfmp_pkg;

  // Default sizes for the top-level parameters
  localparam int MAX_NAME_LEN_DEFAULT = 32;
  localparam int MAX_ELEM_LEN_DEFAULT = 8;
  localparam int MASS_WIDTH_DEFAULT   = 16;

  // Mass table geometry
  localparam int TABLE_COUNT = 23;
  localparam int SYM_CHARS   = 6;
  localparam int IDX_W       = $clog2(TABLE_COUNT);

  // Symbol is left aligned: first character in the top byte, zero padded
  typedef struct packed {
    logic [SYM_CHARS*8-1:0] sym;
    logic [2:0]             len;
    logic [5:0]             mass;
  } entry_t;

  function automatic entry_t table_entry(input logic [IDX_W-1:0] idx);
    entry_t e;
    e = '0;
    unique case (idx)
      5'd0:  e = '{sym: {"H",      40'h0}, len: 3'd1, mass: 6'd1};
      5'd1:  e = '{sym: {"D",      40'h0}, len: 3'd1, mass: 6'd2};
      5'd2:  e = '{sym: {"He",     32'h0}, len: 3'd2, mass: 6'd2};
      5'd3:  e = '{sym: {"C",      40'h0}, len: 3'd1, mass: 6'd12};
      5'd4:  e = '{sym: {"-13-C",   8'h0}, len: 3'd5, mass: 6'd13};
      5'd5:  e = '{sym: {"N",      40'h0}, len: 3'd1, mass: 6'd14};
      5'd6:  e = '{sym: {"-15-N",   8'h0}, len: 3'd5, mass: 6'd15};
      5'd7:  e = '{sym: {"O",      40'h0}, len: 3'd1, mass: 6'd16};
      5'd8:  e = '{sym: {"-17-O",   8'h0}, len: 3'd5, mass: 6'd17};
      5'd9:  e = '{sym: {"-18-O",   8'h0}, len: 3'd5, mass: 6'd18};
      5'd10: e = '{sym: {"F",      40'h0}, len: 3'd1, mass: 6'd19};
      5'd11: e = '{sym: {"Ne",     32'h0}, len: 3'd2, mass: 6'd20};
      5'd12: e = '{sym: {"Na",     32'h0}, len: 3'd2, mass: 6'd23};
      5'd13: e = '{sym: {"Mg",     32'h0}, len: 3'd2, mass: 6'd24};
      5'd14: e = '{sym: {"Si",     32'h0}, len: 3'd2, mass: 6'd28};
      5'd15: e = '{sym: "-29-Si",          len: 3'd6, mass: 6'd29};
      5'd16: e = '{sym: {"S",      40'h0}, len: 3'd1, mass: 6'd30};
      5'd17: e = '{sym: {"P",      40'h0}, len: 3'd1, mass: 6'd31};
      5'd18: e = '{sym: {"Cl",     32'h0}, len: 3'd2, mass: 6'd35};
      5'd19: e = '{sym: {"Fe",     32'h0}, len: 3'd2, mass: 6'd56};
      5'd20: e = '{sym: {"grain",   8'h0}, len: 3'd5, mass: 6'd0};
      5'd21: e = '{sym: {"X",      40'h0}, len: 3'd1, mass: 6'd1};
      5'd22: e = '{sym: {"Y",      40'h0}, len: 3'd1, mass: 6'd1};
      default: e = '0;
    endcase
    return e;
  endfunction

endpackage

### design/chemical_formula_mass_parser_core.sv
// ---------------------------------------------------------------------------
// chemical_formula_mass_parser_core
// Parses a species name one character per item into its integer mass,
// charge, electron flag and error code.
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+-----------
//   in      | in_valid, in_stall, char_code, last       | to core
//   out     | out_valid, out_stall, mass_amu, charge,   | from core
//           | is_electron, mass_saturated, error_code   |
//
// One character is taken every cycle while in_stall is low; the parse stage does one table match
// and one saturating multiply-add per character.
// A name's result passes through a finish register, where the final element
// match runs, and then through the output register.
// in_stall rises only while a finished name waits in the finish register
// behind a stalled output register.
// rst is synchronous; it clears the parse state and both valid flags.
// ---------------------------------------------------------------------------
module chemical_formula_mass_parser_core #(
  parameter int MAX_NAME_LEN = cfmp_pkg::MAX_NAME_LEN_DEFAULT,
  parameter int MAX_ELEM_LEN = cfmp_pkg::MAX_ELEM_LEN_DEFAULT,
  parameter int MASS_WIDTH   = cfmp_pkg::MASS_WIDTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        char_code,
  input  logic              last,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       mass_amu,
  output logic signed [1:0] charge,
  output logic              is_electron,
  output logic              mass_saturated,
  output logic [2:0]        error_code
);

  localparam int LEN_W = $clog2(MAX_ELEM_LEN);
  localparam int SUM_W = MASS_WIDTH + 15;

  // Parse phases
  localparam logic [3:0] PH_ELEM      = 4'd0;
  localparam logic [3:0] PH_NUMBER    = 4'd1;
  localparam logic [3:0] PH_ISO_BODY  = 4'd2;
  localparam logic [3:0] PH_ISO_LAST  = 4'd3;
  localparam logic [3:0] PH_PAREN1    = 4'd4;
  localparam logic [3:0] PH_PAREN2    = 4'd5;
  localparam logic [3:0] PH_ICE_E     = 4'd6;
  localparam logic [3:0] PH_ICE_CLOSE = 4'd7;
  localparam logic [3:0] PH_DONE      = 4'd8;
  localparam logic [3:0] PH_ERROR     = 4'd9;

  // Error codes
  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NAME_LONG = 3'd1;
  localparam logic [2:0] ERR_MALFORMED = 3'd2;
  localparam logic [2:0] ERR_ELEM_LONG = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd4;

  // Characters
  localparam logic [7:0] CH_DASH   = 8'd45;
  localparam logic [7:0] CH_PLUS   = 8'd43;
  localparam logic [7:0] CH_LPAREN = 8'd40;
  localparam logic [7:0] CH_RPAREN = 8'd41;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_ONE    = 8'd49;
  localparam logic [7:0] CH_NINE   = 8'd57;
  localparam logic [7:0] CH_UP_A   = 8'd65;
  localparam logic [7:0] CH_UP_Z   = 8'd90;
  localparam logic [7:0] CH_LO_A   = 8'd97;
  localparam logic [7:0] CH_LO_Z   = 8'd122;
  localparam logic [7:0] CH_C      = 8'd99;
  localparam logic [7:0] CH_E      = 8'd101;
  localparam logic [7:0] CH_I      = 8'd105;

  localparam logic [7:0] ELECTRON_TEXT [4] = '{CH_E, CH_LPAREN, CH_DASH, CH_RPAREN};
  localparam logic [2:0] EM_FULL = 3'd4;
  localparam logic [2:0] EM_MISS = 3'd7;

  localparam logic signed [1:0] CHG_POS  = 2'sb01;
  localparam logic signed [1:0] CHG_NEG  = 2'sb11;
  localparam logic signed [1:0] CHG_NONE = 2'sb00;

  localparam logic [7:0] MULT_ONE = 8'd1;
  localparam logic [7:0] MULT_MAX = 8'd255;
  localparam logic [5:0] NLEN_MAX = 6'd63;

  // Saturating sum + multiplier * mass; returns {saturated, sum}
  function automatic logic [MASS_WIDTH:0] add_mass(input logic [MASS_WIDTH-1:0] s,
                                                   input logic [7:0] m,
                                                   input logic [5:0] w);
    logic [13:0]      p;
    logic [SUM_W-1:0] t;
    p = 14'(m) * 14'(w);
    t = SUM_W'(s) + SUM_W'(p);
    if (t > SUM_W'({MASS_WIDTH{1'b1}})) begin
      return {1'b1, {MASS_WIDTH{1'b1}}};
    end
    return {1'b0, MASS_WIDTH'(t)};
  endfunction

  // ---------------- parse state ----------------
  logic [MAX_ELEM_LEN-1:0][7:0] element_chars, chars_next;
  logic [LEN_W-1:0]             elen, elen_next;
  logic [7:0]                   mult, mult_next;
  logic [MASS_WIDTH-1:0]        sum, sum_next;
  logic                         sat, sat_next;
  logic signed [1:0]            chg, chg_next;
  logic [3:0]                   phase, phase_next;
  logic [5:0]                   nlen, nlen_next;
  logic [2:0]                   err, err_next;
  logic [2:0]                   em, em_next;
  logic [7:0]                   paren, paren_next;

  // ---------------- finish register ----------------
  logic                         fin_valid;
  logic [MAX_ELEM_LEN-1:0][7:0] fin_chars;
  logic [LEN_W-1:0]             fin_len;
  logic [7:0]                   fin_mult;
  logic [MASS_WIDTH-1:0]        fin_sum;
  logic                         fin_sat;
  logic signed [1:0]            fin_chg;
  logic [3:0]                   fin_phase;
  logic [5:0]                   fin_nlen;
  logic [2:0]                   fin_err;
  logic [2:0]                   fin_em;

  logic in_take, out_free, fin_move;
  logic hit_a, hit_b;
  logic [5:0] mass_a, mass_b;

  assign out_free = !out_valid || !out_stall;
  assign fin_move = fin_valid && out_free;
  assign in_stall = fin_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  cfmp_lookup #(.MAX_ELEM_LEN(MAX_ELEM_LEN)) u_lookup_parse (
    .chars(element_chars), .len(elen), .hit(hit_a), .mass(mass_a)
  );

  cfmp_lookup #(.MAX_ELEM_LEN(MAX_ELEM_LEN)) u_lookup_finish (
    .chars(fin_chars), .len(fin_len), .hit(hit_b), .mass(mass_b)
  );

  // ---------------- per-character parse ----------------
  always_comb begin
    logic [7:0]        c;
    logic              do_elem, do_put;
    logic [LEN_W-1:0]  put_len;
    logic [11:0]       mult_wide;
    logic [MASS_WIDTH:0] acc;
    logic              is_upper, is_lower, is_digit, is_nz_digit;
    c           = char_code;
    is_upper    = (c >= CH_UP_A) && (c <= CH_UP_Z);
    is_lower    = (c >= CH_LO_A) && (c <= CH_LO_Z);
    is_digit    = (c >= CH_ZERO) && (c <= CH_NINE);
    is_nz_digit = (c >= CH_ONE) && (c <= CH_NINE);
    do_elem     = 1'b0;
    do_put      = 1'b0;
    put_len     = elen;
    mult_wide   = '0;
    acc         = '0;
    elen_next   = elen;
    mult_next   = mult;
    sum_next    = sum;
    sat_next    = sat;
    chg_next    = chg;
    phase_next  = phase;
    err_next    = err;
    paren_next  = paren;
    chars_next  = element_chars;

    nlen_next = (nlen != NLEN_MAX) ? 6'(nlen + 6'd1) : nlen;
    if ((em < EM_FULL) && (c == ELECTRON_TEXT[em[1:0]])) begin
      em_next = 3'(em + 3'd1);
    end else begin
      em_next = EM_MISS;
    end

    case (phase)
      PH_ELEM: do_elem = 1'b1;
      PH_NUMBER: begin
        if (is_digit) begin
          mult_wide = 12'(mult) * 12'd10 + 12'(c - CH_ZERO);
          if (mult_wide > 12'(MULT_MAX)) begin
            mult_next = MULT_MAX;
            sat_next  = 1'b1;
          end else begin
            mult_next = mult_wide[7:0];
          end
        end else begin
          phase_next = PH_ELEM;
          do_elem    = 1'b1;
        end
      end
      PH_ISO_BODY: begin
        do_put = 1'b1;
        if (c == CH_DASH) begin
          phase_next = PH_ISO_LAST;
        end
      end
      PH_ISO_LAST: begin
        do_put     = 1'b1;
        phase_next = PH_ELEM;
      end
      PH_PAREN1: begin
        paren_next = c;
        phase_next = PH_PAREN2;
      end
      PH_PAREN2: begin
        if (c == CH_RPAREN && paren == CH_PLUS) begin
          chg_next   = CHG_POS;
          phase_next = PH_DONE;
        end else if (c == CH_RPAREN && paren == CH_DASH) begin
          chg_next   = CHG_NEG;
          phase_next = PH_DONE;
        end else if (c != CH_RPAREN && paren == CH_I && c == CH_C) begin
          phase_next = PH_ICE_E;
        end else begin
          phase_next = PH_ERROR;
          err_next   = ERR_MALFORMED;
        end
      end
      PH_ICE_E: begin
        if (c == CH_E) begin
          phase_next = PH_ICE_CLOSE;
        end else begin
          phase_next = PH_ERROR;
          err_next   = ERR_MALFORMED;
        end
      end
      PH_ICE_CLOSE: begin
        if (c == CH_RPAREN) begin
          phase_next = PH_DONE;
        end else begin
          phase_next = PH_ERROR;
          err_next   = ERR_MALFORMED;
        end
      end
      default: ;  // done or error: drop further characters
    endcase

    if (do_elem) begin
      priority if (c == CH_DASH || is_upper) begin
        // a new element starts: close the one held so far
        if (elen != '0) begin
          if (hit_a) begin
            acc       = add_mass(sum, mult, mass_a);
            sum_next  = acc[MASS_WIDTH-1:0];
            sat_next  = sat_next | acc[MASS_WIDTH];
            put_len   = '0;
            elen_next = '0;
            mult_next = MULT_ONE;
          end else begin
            phase_next = PH_ERROR;
            err_next   = ERR_UNKNOWN;
          end
        end
        if (phase_next != PH_ERROR) begin
          do_put = 1'b1;
          if (c == CH_DASH) begin
            phase_next = PH_ISO_BODY;
          end
        end
      end else if (is_lower) begin
        do_put = 1'b1;
      end else if (is_nz_digit) begin
        if (elen == '0 || mult != MULT_ONE) begin
          phase_next = PH_ERROR;
          err_next   = ERR_MALFORMED;
        end else begin
          mult_next  = 8'(c - CH_ZERO);
          phase_next = PH_NUMBER;
        end
      end else if (c == CH_LPAREN) begin
        phase_next = PH_PAREN1;
      end else begin
        phase_next = PH_ERROR;
        err_next   = ERR_MALFORMED;
      end
    end

    if (do_put) begin
      if (put_len >= LEN_W'(MAX_ELEM_LEN - 1)) begin
        phase_next = PH_ERROR;
        err_next   = ERR_ELEM_LONG;
      end else begin
        chars_next[put_len] = c;
        elen_next           = LEN_W'(put_len + 1'b1);
      end
    end
  end

  // Parse state; return to the start after the last character
  always_ff @(posedge clk) begin
    if (rst) begin
      elen  <= '0;
      mult  <= MULT_ONE;
      sum   <= '0;
      sat   <= 1'b0;
      chg   <= CHG_NONE;
      phase <= PH_ELEM;
      nlen  <= '0;
      err   <= ERR_NONE;
      em    <= '0;
      paren <= '0;
    end else if (in_take) begin
      if (last) begin
        elen  <= '0;
        mult  <= MULT_ONE;
        sum   <= '0;
        sat   <= 1'b0;
        chg   <= CHG_NONE;
        phase <= PH_ELEM;
        nlen  <= '0;
        err   <= ERR_NONE;
        em    <= '0;
        paren <= '0;
      end else begin
        elen  <= elen_next;
        mult  <= mult_next;
        sum   <= sum_next;
        sat   <= sat_next;
        chg   <= chg_next;
        phase <= phase_next;
        nlen  <= nlen_next;
        err   <= err_next;
        em    <= em_next;
        paren <= paren_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      element_chars <= chars_next;
    end
  end

  // Finish register: snapshot of the name at its last character
  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (in_take && last) begin
      fin_valid <= 1'b1;
    end else if (fin_move) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take && last) begin
      fin_chars <= chars_next;
      fin_len   <= elen_next;
      fin_mult  <= mult_next;
      fin_sum   <= sum_next;
      fin_sat   <= sat_next;
      fin_chg   <= chg_next;
      fin_phase <= phase_next;
      fin_nlen  <= nlen_next;
      fin_err   <= err_next;
      fin_em    <= em_next;
    end
  end

  // ---------------- final flush and result ----------------
  logic [15:0]       res_mass;
  logic signed [1:0] res_chg;
  logic              res_elec, res_sat;
  logic [2:0]        res_err;

  always_comb begin
    logic [MASS_WIDTH:0]   acc;
    logic [MASS_WIDTH-1:0] fsum;
    logic                  fsat;
    logic [2:0]            ferr;
    acc  = '0;
    fsum = fin_sum;
    fsat = fin_sat;
    ferr = fin_err;
    if (fin_phase == PH_ELEM || fin_phase == PH_NUMBER || fin_phase == PH_DONE) begin
      if (fin_len != '0) begin
        if (hit_b) begin
          acc  = add_mass(fin_sum, fin_mult, mass_b);
          fsum = acc[MASS_WIDTH-1:0];
          fsat = fin_sat | acc[MASS_WIDTH];
        end else begin
          ferr = ERR_UNKNOWN;
        end
      end
    end else if (fin_phase != PH_ERROR) begin
      ferr = ERR_MALFORMED;  // name ended inside a prefix or parenthesis
    end

    if (fin_nlen >= 6'(MAX_NAME_LEN - 1)) begin
      ferr = ERR_NAME_LONG;
    end

    if (fin_em == EM_FULL) begin
      res_mass = '0;
      res_chg  = CHG_NEG;
      res_elec = 1'b1;
      res_sat  = 1'b0;
      res_err  = ERR_NONE;
    end else if (ferr != ERR_NONE) begin
      res_mass = '0;
      res_chg  = CHG_NONE;
      res_elec = 1'b0;
      res_sat  = 1'b0;
      res_err  = ferr;
    end else begin
      res_mass = 16'(fsum);
      res_chg  = fin_chg;
      res_elec = 1'b0;
      res_sat  = fsat;
      res_err  = ERR_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fin_move) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_move) begin
      mass_amu       <= res_mass;
      charge         <= res_chg;
      is_electron    <= res_elec;
      mass_saturated <= res_sat;
      error_code     <= res_err;
    end
  end

  // ---------------- checks ----------------
  a_electron_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_electron |-> charge == CHG_NEG && mass_amu == '0 &&
                                 error_code == ERR_NONE)
    else $error("electron result carries mass, charge or error");

  a_error_clears: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code != ERR_NONE |-> mass_amu == '0 && charge == CHG_NONE &&
                                            !mass_saturated && !is_electron)
    else $error("error result carries payload");

  a_restart: assert property (@(posedge clk) disable iff (rst)
    in_take && last |=> phase == PH_ELEM && elen == '0 && nlen == '0 &&
                        err == ERR_NONE && fin_valid)
    else $error("parse state not restarted after last character");

  a_error_phase: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_ERROR) == (err != ERR_NONE))
    else $error("error code and error phase disagree");

  a_finish_drains: assert property (@(posedge clk) disable iff (rst)
    fin_valid && out_free |=> out_valid)
    else $error("finished name did not reach the output register");

endmodule

### design/cfmp_lookup.sv
// ---------------------------------------------------------------------------
// cfmp_lookup
// Parallel match of the collected element name against every mass table
// entry; returns a hit flag and the element mass.
// ---------------------------------------------------------------------------
module cfmp_lookup #(
  parameter int MAX_ELEM_LEN = cfmp_pkg::MAX_ELEM_LEN_DEFAULT,
  localparam int LEN_W = $clog2(MAX_ELEM_LEN)
) (
  input  logic [MAX_ELEM_LEN-1:0][7:0] chars,
  input  logic [LEN_W-1:0]             len,
  output logic                         hit,
  output logic [5:0]                   mass
);

  // Only positions within both the element buffer and the table symbol width take part in the compare
  localparam int CMP_N = (MAX_ELEM_LEN < cfmp_pkg::SYM_CHARS) ?
                         MAX_ELEM_LEN : cfmp_pkg::SYM_CHARS;

  always_comb begin
    cfmp_pkg::entry_t e;
    logic             same;
    hit  = 1'b0;
    mass = '0;
    for (int i = 0; i < cfmp_pkg::TABLE_COUNT; i++) begin
      e    = cfmp_pkg::table_entry(cfmp_pkg::IDX_W'(i));
      same = (4'(len) == 4'(e.len));
      for (int k = 0; k < CMP_N; k++) begin
        if ((k < int'(e.len)) &&
            (chars[k] != e.sym[cfmp_pkg::SYM_CHARS*8-1-8*k -: 8])) begin
          same = 1'b0;
        end
      end
      // table symbols are distinct, so at most one entry hits
      if (same) begin
        hit  = 1'b1;
        mass = mass | e.mass;
      end
    end
  end

endmodule

### sim/chemical_formula_mass_parser_core_tb.sv
// ---------------------------------------------------------------------------
// chemical_formula_mass_parser_core_tb
// Streams species names into the parser one character per item and checks
// every result against a behavioral mass, charge and error predictor. Both
// channels see random idle bursts until the tail of the run.
// ---------------------------------------------------------------------------
module chemical_formula_mass_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NAME_LIMIT  = cfmp_pkg::MAX_NAME_LEN_DEFAULT;
  localparam int ELEM_LIMIT  = cfmp_pkg::MAX_ELEM_LEN_DEFAULT;
  localparam int ELEM_COUNT  = cfmp_pkg::TABLE_COUNT;
  localparam int MASS_CEIL   = 65535;
  localparam int ITEM_TARGET = 2000;
  localparam int CALM_TAIL   = 150;

  localparam logic [2:0] ERR_NONE      = 3'd0;
  localparam logic [2:0] ERR_NAME_LONG = 3'd1;
  localparam logic [2:0] ERR_MALFORMED = 3'd2;
  localparam logic [2:0] ERR_ELEM_LONG = 3'd3;
  localparam logic [2:0] ERR_UNKNOWN   = 3'd4;

  localparam logic [7:0] CH_LPAREN = 8'd40;
  localparam logic [7:0] CH_RPAREN = 8'd41;
  localparam logic [7:0] CH_PLUS   = 8'd43;
  localparam logic [7:0] CH_DASH   = 8'd45;
  localparam logic [7:0] CH_ZERO   = 8'd48;
  localparam logic [7:0] CH_ONE    = 8'd49;
  localparam logic [7:0] CH_NINE   = 8'd57;
  localparam logic [7:0] CH_UP_A   = 8'd65;
  localparam logic [7:0] CH_UP_Z   = 8'd90;
  localparam logic [7:0] CH_LO_A   = 8'd97;
  localparam logic [7:0] CH_LO_C   = 8'd99;
  localparam logic [7:0] CH_LO_E   = 8'd101;
  localparam logic [7:0] CH_LO_I   = 8'd105;
  localparam logic [7:0] CH_LO_Z   = 8'd122;

  typedef enum logic [3:0] {
    SCAN_ELEM, SCAN_MULT, SCAN_ISO_BODY, SCAN_ISO_LAST, SCAN_PAREN_OPEN,
    SCAN_PAREN_CLOSE, SCAN_ICE_E, SCAN_ICE_CLOSE, SCAN_DONE, SCAN_ERROR
  } scan_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       fin;
  } char_item_t;

  typedef struct packed {
    logic [15:0] mass;
    logic [1:0]  chg;
    logic        elec;
    logic        sat;
    logic [2:0]  err;
  } mass_result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [7:0]        char_code = 8'd0;
  logic              last = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [15:0]       mass_amu;
  logic signed [1:0] charge;
  logic              is_electron;
  logic              mass_saturated;
  logic [2:0]        error_code;

  chemical_formula_mass_parser_core dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .char_code      (char_code),
    .last           (last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .mass_amu       (mass_amu),
    .charge         (charge),
    .is_electron    (is_electron),
    .mass_saturated (mass_saturated),
    .error_code     (error_code)
  );

  always #2 clk = ~clk;

  string elem_sym [ELEM_COUNT] = '{
    "H", "D", "He", "C", "-13-C", "N", "-15-N", "O", "-17-O", "-18-O", "F",
    "Ne", "Na", "Mg", "Si", "-29-Si", "S", "P", "Cl", "Fe", "grain", "X", "Y"
  };
  int elem_mass [ELEM_COUNT] = '{
    1, 2, 2, 12, 13, 14, 15, 16, 17, 18, 19,
    20, 23, 24, 28, 29, 30, 31, 35, 56, 0, 1, 1
  };
  string electron_name = "e(-)";

  // Parser state mirrored by the predictor
  logic [7:0]      sym_buf [ELEM_LIMIT];
  int              sym_len;
  int              mult;
  longint unsigned mass_acc;
  logic [1:0]      ion_charge;
  scan_t           scan;
  int              name_cnt;
  logic [2:0]      err_hold;
  int              e_match;
  bit              sat;
  logic [7:0]      paren_c;

  char_item_t   feed_q [$];
  mass_result_t results_due [$];
  logic [7:0]   draft [$];
  int           mismatches = 0;
  int           feed_idle, feed_odds, drain_idle, drain_odds;
  char_item_t   next_item;
  mass_result_t fed_res, seen_res, want_res;

  // No idling once the feed is nearly drained
  function bit wind_down();
    return feed_q.size() < CALM_TAIL;
  endfunction

  function void clear_parse();
    sym_len    = 0;
    mult       = 1;
    mass_acc   = 0;
    ion_charge = 2'b00;
    scan       = SCAN_ELEM;
    name_cnt   = 0;
    err_hold   = ERR_NONE;
    e_match    = 0;
    sat        = 1'b0;
    paren_c    = 8'd0;
  endfunction

  function void raise_error(input logic [2:0] code);
    if (scan != SCAN_ERROR) begin
      err_hold = code;
      scan     = SCAN_ERROR;
    end
  endfunction

  function void hold_char(input logic [7:0] c);
    if (sym_len >= ELEM_LIMIT - 1) begin
      raise_error(ERR_ELEM_LONG);
    end else begin
      sym_buf[sym_len] = c;
      sym_len++;
    end
  endfunction

  // Look up the held element and add its mass times the multiplier
  function void close_element();
    int  i, k;
    bit  same;
    if (sym_len == 0) return;
    for (i = 0; i < ELEM_COUNT; i++) begin
      same = (elem_sym[i].len() == sym_len);
      for (k = 0; same && k < sym_len; k++)
        if (elem_sym[i][k] != sym_buf[k]) same = 1'b0;
      if (same) begin
        mass_acc += mult * elem_mass[i];
        if (mass_acc > MASS_CEIL) begin
          mass_acc = MASS_CEIL;
          sat      = 1'b1;
        end
        sym_len = 0;
        mult    = 1;
        return;
      end
    end
    raise_error(ERR_UNKNOWN);
  endfunction

  function void take_elem_char(input logic [7:0] c);
    if (c == CH_DASH || (c >= CH_UP_A && c <= CH_UP_Z)) begin
      close_element();
      if (scan == SCAN_ERROR) return;
      hold_char(c);
      if (c == CH_DASH && scan != SCAN_ERROR) scan = SCAN_ISO_BODY;
    end else if (c >= CH_LO_A && c <= CH_LO_Z) begin
      hold_char(c);
    end else if (c >= CH_ONE && c <= CH_NINE) begin
      if (sym_len == 0 || mult != 1) begin
        raise_error(ERR_MALFORMED);
      end else begin
        mult = int'(c) - int'(CH_ZERO);
        scan = SCAN_MULT;
      end
    end else if (c == CH_LPAREN) begin
      scan = SCAN_PAREN_OPEN;
    end else begin
      raise_error(ERR_MALFORMED);
    end
  endfunction

  // Advance the parse by one character; return 1 with the result on the last one
  function bit predict_char(input logic [7:0] c, input logic fin, output mass_result_t r);
    logic [2:0] code;
    r = '0;
    if (name_cnt < 63) name_cnt++;
    if (e_match < 4 && c == electron_name[e_match]) e_match++;
    else e_match = 7;

    case (scan)
      SCAN_ELEM: take_elem_char(c);
      SCAN_MULT: begin
        if (c >= CH_ZERO && c <= CH_NINE) begin
          mult = mult * 10 + (int'(c) - int'(CH_ZERO));
          if (mult > 255) begin
            mult = 255;
            sat  = 1'b1;
          end
        end else begin
          scan = SCAN_ELEM;
          take_elem_char(c);
        end
      end
      SCAN_ISO_BODY: begin
        hold_char(c);
        if (scan != SCAN_ERROR && c == CH_DASH) scan = SCAN_ISO_LAST;
      end
      SCAN_ISO_LAST: begin
        hold_char(c);
        if (scan != SCAN_ERROR) scan = SCAN_ELEM;
      end
      SCAN_PAREN_OPEN: begin
        paren_c = c;
        scan    = SCAN_PAREN_CLOSE;
      end
      SCAN_PAREN_CLOSE: begin
        if (c == CH_RPAREN) begin
          if (paren_c == CH_PLUS) begin
            ion_charge = 2'b01;
            scan       = SCAN_DONE;
          end else if (paren_c == CH_DASH) begin
            ion_charge = 2'b11;
            scan       = SCAN_DONE;
          end else begin
            raise_error(ERR_MALFORMED);
          end
        end else if (paren_c == CH_LO_I && c == CH_LO_C) begin
          scan = SCAN_ICE_E;
        end else begin
          raise_error(ERR_MALFORMED);
        end
      end
      SCAN_ICE_E: begin
        if (c == CH_LO_E) scan = SCAN_ICE_CLOSE;
        else raise_error(ERR_MALFORMED);
      end
      SCAN_ICE_CLOSE: begin
        if (c == CH_RPAREN) scan = SCAN_DONE;
        else raise_error(ERR_MALFORMED);
      end
      default: ;
    endcase

    if (!fin) return 1'b0;

    if (scan == SCAN_ELEM || scan == SCAN_MULT || scan == SCAN_DONE) close_element();
    else if (scan != SCAN_ERROR) raise_error(ERR_MALFORMED);

    if (e_match == 4) begin
      r.chg  = 2'b11;
      r.elec = 1'b1;
      r.err  = ERR_NONE;
    end else begin
      code = (scan == SCAN_ERROR) ? err_hold : ERR_NONE;
      if (name_cnt >= NAME_LIMIT - 1) code = ERR_NAME_LONG;
      if (code == ERR_NONE) begin
        r.mass = mass_acc[15:0];
        r.chg  = ion_charge;
        r.sat  = sat;
      end
      r.err = code;
    end
    clear_parse();
    return 1'b1;
  endfunction

  // Name construction
  function automatic logic [7:0] noise_char();
    string pool = "HDCNOFSPXYegrainlMgSiz-0123456789()+-ice";
    if ($urandom_range(0, 1)) return pool[$urandom_range(0, pool.len() - 1)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) draft.push_back(s[i]);
  endtask

  task automatic add_formula(input int n);
    int idx, extra;
    repeat (n) begin
      idx = $urandom_range(0, ELEM_COUNT - 1);
      add_text(elem_sym[idx]);
      if ($urandom_range(0, 1)) begin
        draft.push_back(8'($urandom_range(CH_ONE, CH_NINE)));
        extra = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 4) : $urandom_range(0, 1);
        repeat (extra) draft.push_back(8'($urandom_range(CH_ZERO, CH_NINE)));
      end
    end
  endtask

  task automatic add_suffix();
    case ($urandom_range(0, 9))
      5: add_text("(+)");
      6: add_text("(-)");
      7: add_text("(ice)");
      8: begin
        case ($urandom_range(0, 5))
          0: add_text("(");
          1: add_text("(+");
          2: add_text("(x)");
          3: add_text("(ic");
          4: add_text("(icx)");
          default: add_text("(i)");
        endcase
      end
      9: begin
        // trailing text after a charge or ice suffix is ignored
        add_text(($urandom_range(0, 1)) ? "(+)" : "(ice)");
        repeat ($urandom_range(1, 3)) draft.push_back(noise_char());
      end
      default: ;
    endcase
  endtask

  task automatic mutate_draft();
    int idx, keep;
    if (draft.size() == 0) return;
    idx = $urandom_range(0, draft.size() - 1);
    case ($urandom_range(0, 3))
      0: draft[idx] = noise_char();
      1: if (draft.size() > 1) draft.delete(idx);
      2: begin
        keep = $urandom_range(1, draft.size());
        while (draft.size() > keep) void'(draft.pop_back());
      end
      default: draft.insert(idx, noise_char());
    endcase
  endtask

  task automatic push_draft();
    char_item_t it;
    for (int i = 0; i < draft.size(); i++) begin
      it.ch  = draft[i];
      it.fin = (i == draft.size() - 1);
      feed_q.push_back(it);
    end
    draft.delete();
  endtask

  task automatic push_text(input string s);
    add_text(s);
    push_draft();
  endtask

  // Driver
  always @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      feed_idle = 0;
      feed_odds = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (predict_char(char_code, last, fed_res)) results_due.push_back(fed_res);
      end
      if (!in_valid || !in_stall) begin
        if ($urandom_range(0, 127) == 0) feed_odds = $urandom_range(0, 2) * 6;
        if (feed_idle == 0 && !wind_down() && feed_odds != 0 &&
            $urandom_range(0, feed_odds) == 0)
          feed_idle = $urandom_range(1, 8);
        if (feed_idle > 0 || feed_q.size() == 0) begin
          if (feed_idle > 0) feed_idle--;
          in_valid <= 1'b0;
        end else begin
          next_item = feed_q.pop_front();
          in_valid  <= 1'b1;
          char_code <= next_item.ch;
          last      <= next_item.fin;
        end
      end
    end
  end

  // Monitor
  always @(posedge clk) begin
    if (rst) begin
      out_stall  <= 1'b0;
      drain_idle = 0;
      drain_odds = 0;
    end else begin
      if (out_valid && !out_stall) begin
        seen_res = '{mass: mass_amu, chg: charge, elec: is_electron,
                     sat: mass_saturated, err: error_code};
        if (results_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result at %0t: mass %0d charge %0d elec %0b sat %0b err %0d",
                     $realtime, seen_res.mass, $signed(seen_res.chg), seen_res.elec,
                     seen_res.sat, seen_res.err);
        end else begin
          want_res = results_due.pop_front();
          if (seen_res !== want_res) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"mismatch at %0t: expected mass %0d charge %0d elec %0b sat %0b",
                        " err %0d, got mass %0d charge %0d elec %0b sat %0b err %0d"},
                       $realtime, want_res.mass, $signed(want_res.chg), want_res.elec,
                       want_res.sat, want_res.err, seen_res.mass, $signed(seen_res.chg),
                       seen_res.elec, seen_res.sat, seen_res.err);
          end
        end
      end
      if ($urandom_range(0, 127) == 0) drain_odds = $urandom_range(0, 2) * 6;
      if (drain_idle == 0 && !wind_down() && drain_odds != 0 &&
          $urandom_range(0, drain_odds) == 0)
        drain_idle = $urandom_range(1, 8);
      if (drain_idle > 0) begin
        drain_idle--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    int pick, len;
    clear_parse();

    // Electron, isotope with ice, saturated multiplier, extreme bytes, a plain element
    push_text("e(-)");
    push_text("-13-CH(ice)");
    push_text("Fe999");
    draft.push_back(8'h00);
    push_draft();
    draft.push_back(8'hff);
    push_draft();
    push_text("X");

    while (feed_q.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        add_formula($urandom_range(1, 4));
        add_suffix();
      end else if (pick < 64) begin
        // drive the mass sum into saturation
        repeat ($urandom_range(5, 6)) add_text("Fe255");
        add_suffix();
      end else if (pick < 80) begin
        add_formula($urandom_range(1, 4));
        add_suffix();
        mutate_draft();
      end else if (pick < 88) begin
        repeat ($urandom_range(1, 8)) draft.push_back(noise_char());
      end else if (pick < 91) begin
        add_text("H");
        repeat ($urandom_range(4, 9)) draft.push_back(8'($urandom_range(CH_LO_A, CH_LO_Z)));
      end else if (pick < 95) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(33, 70) : $urandom_range(29, 32);
        repeat (len) draft.push_back(($urandom_range(0, 3) == 0) ? "C" : "H");
      end else begin
        case ($urandom_range(0, 4))
          0: add_text("e(-)");
          1: add_text("e(+)");
          2: add_text("e(-)H");
          3: add_text("e(");
          default: add_text("e");
        endcase
      end
      push_draft();
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (feed_q.size() > 0 || in_valid) @(posedge clk);
    while (results_due.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0 && results_due.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
